// ===== rtl/diec_pkg.sv =====
package diec_pkg;

   localparam int DOSE_WIDTH = 41;
   localparam int SECONDS_WIDTH = 9;
   localparam int ADC_WIDTH = 12;
   localparam int GAIN_WIDTH = 20;
   localparam int SETTING_WIDTH = 4;
   localparam int PRODUCT_WIDTH = GAIN_WIDTH + ADC_WIDTH;
   localparam int TARGET_BASE_WIDTH = 10;
   localparam int REPORT_BATCH_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = GAIN_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOSE_SETTING = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_PER_CODE = 1'b1;

   localparam logic [SETTING_WIDTH-1:0] DOSE_SETTING_RESET = 4'd0;
   localparam logic [GAIN_WIDTH-1:0] GAIN_PER_CODE_RESET = 20'd84582;

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   typedef enum logic [1:0] {
      END_NONE = 2'd0,
      END_TARGET = 2'd1,
      END_STOPPED = 2'd2,
      END_TIMEOUT = 2'd3
   } end_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_EVAL,
      ST_DIVIDE,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic mode;
      logic [ADC_WIDTH-1:0] adc_code;
      logic stop_pressed;
   } req_type;

   typedef struct packed {
      logic coil_on;
      logic active_led;
      logic [SECONDS_WIDTH-1:0] seconds;
      logic [DOSE_WIDTH-1:0] dose_accum;
      logic [DOSE_WIDTH-1:0] dose_mean;
      logic [REPORT_BATCH_WIDTH-1:0] batch_number;
      logic [1:0] end_status;
      logic run_done;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic eval;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic rsp_free;
   } status_type;

   function automatic logic [TARGET_BASE_WIDTH-1:0] dose_target_base(
      input logic [SETTING_WIDTH-1:0] setting);
      logic [TARGET_BASE_WIDTH-1:0] scale;
      logic [TARGET_BASE_WIDTH-1:0] mult;
      scale = setting[3] ? 10'd100 : 10'd10;
      mult = {7'd0, setting[2:0]} + 10'd1;
      return TARGET_BASE_WIDTH'(scale * mult);
   endfunction

endpackage

// ===== rtl/dose_integrating_exposure_controller_top.sv =====
// Exposure controller that integrates gain_per_code times the sensor code on every
// one-second tick into a saturating dose with FRACTION_BITS fraction bits and ends
// the run on stop, on the tick past MAX_SECONDS, or when the dose reaches
// 10^(bit3+1) * (bits2..0 + 1) of dose_setting. Every accepted item produces exactly
// one result, which also carries the truncated average dose per second. An item
// passes through capture, update, end test, the bit-serial divider and load of the
// output register, and the next item is taken once that result sits in the output
// register; the divider forms one of the 41 quotient bits of the average per cycle.
// Configuration writes are accepted in every cycle and must be made only while the
// block is idle.
module dose_integrating_exposure_controller_top #(
   parameter int MAX_SECONDS = 300,
   parameter int FRACTION_BITS = 24,
   parameter int BATCH_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  diec_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output diec_pkg::rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [diec_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [diec_pkg::CSR_DATA_WIDTH-1:0] csr_data
);

   diec_pkg::cmd_type cmd;
   diec_pkg::status_type status;

   diec_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status(status),
      .cmd(cmd)
   );

   diec_datapath #(
      .MAX_SECONDS(MAX_SECONDS),
      .FRACTION_BITS(FRACTION_BITS),
      .BATCH_WIDTH(BATCH_WIDTH)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .cmd(cmd),
      .status(status)
   );

endmodule

// ===== rtl/diec_ctrl.sv =====
module diec_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  diec_pkg::status_type status,
   output diec_pkg::cmd_type cmd
);

   diec_pkg::ctrl_state_type state_ff;
   diec_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= diec_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         diec_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = diec_pkg::ST_UPDATE;
            end
         end
         diec_pkg::ST_UPDATE: begin
            state_in = diec_pkg::ST_EVAL;
         end
         diec_pkg::ST_EVAL: begin
            state_in = diec_pkg::ST_DIVIDE;
         end
         diec_pkg::ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = diec_pkg::ST_EMIT;
            end
         end
         diec_pkg::ST_EMIT: begin
            if (status.rsp_free) begin
               state_in = diec_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = diec_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         diec_pkg::ST_IDLE: begin
            req_stall = reset;
            cmd.capture = req_valid && !reset;
         end
         diec_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         diec_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
         end
         diec_pkg::ST_DIVIDE: begin
         end
         diec_pkg::ST_EMIT: begin
            cmd.emit = status.rsp_free;
         end
         default: begin
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   a_divide_to_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == diec_pkg::ST_DIVIDE && status.div_done) |=>
         (state_ff == diec_pkg::ST_EMIT))
      else $error("divider completion did not lead to result transfer");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.rsp_free)
      else $error("result loaded while output register is occupied");
`endif

endmodule

// ===== rtl/diec_div.sv =====
module diec_div (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [diec_pkg::DOSE_WIDTH-1:0] dividend,
   input  logic [diec_pkg::SECONDS_WIDTH-1:0] divisor,
   output logic done,
   output logic [diec_pkg::DOSE_WIDTH-1:0] quotient
);

   localparam int CountWidth = $clog2(diec_pkg::DOSE_WIDTH);

   logic busy_ff;
   logic busy_in;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic [diec_pkg::DOSE_WIDTH-1:0] quot_ff;
   logic [diec_pkg::DOSE_WIDTH-1:0] quot_in;
   logic [diec_pkg::SECONDS_WIDTH-1:0] rem_ff;
   logic [diec_pkg::SECONDS_WIDTH-1:0] rem_in;
   logic [diec_pkg::SECONDS_WIDTH-1:0] divisor_ff;
   logic [diec_pkg::SECONDS_WIDTH-1:0] divisor_in;
   logic [diec_pkg::SECONDS_WIDTH:0] trial;
   logic fits;

   assign trial = {rem_ff, quot_ff[diec_pkg::DOSE_WIDTH-1]};
   assign fits = trial >= {1'b0, divisor_ff};
   assign done = busy_ff && (count_ff == '0);
   assign quotient = quot_ff;

   always_comb begin
      busy_in = busy_ff;
      count_in = count_ff;
      quot_in = quot_ff;
      rem_in = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in = 1'b1;
         count_in = CountWidth'(diec_pkg::DOSE_WIDTH - 1);
         quot_in = dividend;
         rem_in = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[diec_pkg::DOSE_WIDTH-2:0], fits};
         rem_in = fits ? diec_pkg::SECONDS_WIDTH'(trial - {1'b0, divisor_ff})
                       : trial[diec_pkg::SECONDS_WIDTH-1:0];
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      count_ff <= count_in;
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      divisor_ff <= divisor_in;
   end

`ifndef NO_ASSERTIONS
   a_busy_holds: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && count_ff != '0 && !start) |=> busy_ff)
      else $error("divider stopped before all quotient bits were formed");
`endif

endmodule

// ===== rtl/diec_datapath.sv =====
module diec_datapath #(
   parameter int MAX_SECONDS = 300,
   parameter int FRACTION_BITS = 24,
   parameter int BATCH_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  diec_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output diec_pkg::rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [diec_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [diec_pkg::CSR_DATA_WIDTH-1:0] csr_data,
   input  diec_pkg::cmd_type cmd,
   output diec_pkg::status_type status
);

   localparam int DW = diec_pkg::DOSE_WIDTH;
   localparam int SW = diec_pkg::SECONDS_WIDTH;
   localparam int PW = diec_pkg::PRODUCT_WIDTH;

   logic [diec_pkg::SETTING_WIDTH-1:0] setting_ff;
   logic [diec_pkg::SETTING_WIDTH-1:0] setting_in;
   logic [diec_pkg::GAIN_WIDTH-1:0] gain_ff;
   logic [diec_pkg::GAIN_WIDTH-1:0] gain_in;
   logic running_ff;
   logic running_in;
   logic indicator_ff;
   logic indicator_in;
   logic [SW-1:0] tick_ff;
   logic [SW-1:0] tick_in;
   logic [DW-1:0] dose_ff;
   logic [DW-1:0] dose_in;
   logic [BATCH_WIDTH-1:0] batch_ff;
   logic [BATCH_WIDTH-1:0] batch_in;
   logic pending_ff;
   logic pending_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   diec_pkg::rsp_type rsp_ff;
   diec_pkg::rsp_type rsp_in;
   logic mode_ff;
   logic mode_in;
   logic stop_ff;
   logic stop_in;
   logic [PW-1:0] product_ff;
   logic [PW-1:0] product_in;
   logic [SW:0] next_ff;
   logic [SW:0] next_in;
   logic tick_active_ff;
   logic tick_active_in;
   diec_pkg::end_status_type end_ff;
   diec_pkg::end_status_type end_in;
   logic [BATCH_WIDTH-1:0] report_batch_ff;
   logic [BATCH_WIDTH-1:0] report_batch_in;

   logic [DW:0] dose_sum;
   logic [SW:0] tick_next;
   logic [DW-1:0] target;
   diec_pkg::end_status_type eval_status;
   logic div_done;
   logic [DW-1:0] quotient;

   assign dose_sum = {1'b0, dose_ff} + {{(DW + 1 - PW){1'b0}}, product_ff};
   assign tick_next = {1'b0, tick_ff} + {{SW{1'b0}}, 1'b1};
   assign target = {{(DW - diec_pkg::TARGET_BASE_WIDTH){1'b0}},
                    diec_pkg::dose_target_base(setting_ff)} << FRACTION_BITS;

   always_comb begin
      priority if (!tick_active_ff) begin
         eval_status = diec_pkg::END_NONE;
      end else if (stop_ff) begin
         eval_status = diec_pkg::END_STOPPED;
      end else if (next_ff > (SW + 1)'(MAX_SECONDS)) begin
         eval_status = diec_pkg::END_TIMEOUT;
      end else if (dose_ff >= target) begin
         eval_status = diec_pkg::END_TARGET;
      end else begin
         eval_status = diec_pkg::END_NONE;
      end
   end

   diec_div u_div (
      .clock(clock),
      .reset(reset),
      .start(cmd.eval),
      .dividend(dose_ff),
      .divisor(tick_ff),
      .done(div_done),
      .quotient(quotient)
   );

   assign status.div_done = div_done;
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      setting_in = setting_ff;
      gain_in = gain_ff;
      running_in = running_ff;
      indicator_in = indicator_ff;
      tick_in = tick_ff;
      dose_in = dose_ff;
      batch_in = batch_ff;
      pending_in = pending_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      mode_in = mode_ff;
      stop_in = stop_ff;
      product_in = product_ff;
      next_in = next_ff;
      tick_active_in = tick_active_ff;
      end_in = end_ff;
      report_batch_in = report_batch_ff;

      if (csr_valid) begin
         unique case (csr_index)
            diec_pkg::CSR_DOSE_SETTING: begin
               setting_in = csr_data[diec_pkg::SETTING_WIDTH-1:0];
            end
            diec_pkg::CSR_GAIN_PER_CODE: begin
               gain_in = csr_data;
            end
            default: begin
            end
         endcase
      end

      if (cmd.capture) begin
         mode_in = req_data.mode;
         stop_in = req_data.stop_pressed;
         product_in = {{(PW - diec_pkg::GAIN_WIDTH){1'b0}}, gain_ff} *
                      {{(PW - diec_pkg::ADC_WIDTH){1'b0}}, req_data.adc_code};
      end

      if (cmd.update) begin
         tick_active_in = 1'b0;
         if (mode_ff == diec_pkg::MODE_START) begin
            if (running_ff) begin
               pending_in = 1'b1;
            end else begin
               running_in = 1'b1;
               indicator_in = 1'b1;
               tick_in = '0;
               dose_in = '0;
               pending_in = 1'b0;
            end
         end else if (running_ff) begin
            tick_active_in = 1'b1;
            indicator_in = !indicator_ff;
            next_in = tick_next;
            tick_in = tick_next[SW] ? {SW{1'b1}} : tick_next[SW-1:0];
            dose_in = dose_sum[DW] ? {DW{1'b1}} : dose_sum[DW-1:0];
         end
      end

      if (cmd.eval) begin
         end_in = eval_status;
         report_batch_in = batch_ff;
         if (eval_status != diec_pkg::END_NONE) begin
            running_in = 1'b0;
            indicator_in = 1'b0;
            batch_in = batch_ff + {{(BATCH_WIDTH - 1){1'b0}}, 1'b1};
         end
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_in.coil_on = running_ff;
         rsp_in.active_led = indicator_ff;
         rsp_in.seconds = tick_ff;
         rsp_in.dose_accum = dose_ff;
         rsp_in.dose_mean = (tick_ff == '0) ? '0 : quotient;
         rsp_in.batch_number = diec_pkg::REPORT_BATCH_WIDTH'(report_batch_ff);
         rsp_in.end_status = end_ff;
         rsp_in.run_done = (end_ff != diec_pkg::END_NONE);
         if ((end_ff != diec_pkg::END_NONE) && pending_ff) begin
            running_in = 1'b1;
            indicator_in = 1'b1;
            tick_in = '0;
            dose_in = '0;
            pending_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setting_ff <= diec_pkg::DOSE_SETTING_RESET;
         gain_ff <= diec_pkg::GAIN_PER_CODE_RESET;
         running_ff <= 1'b0;
         indicator_ff <= 1'b0;
         tick_ff <= '0;
         dose_ff <= '0;
         batch_ff <= {{(BATCH_WIDTH - 1){1'b0}}, 1'b1};
         pending_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         setting_ff <= setting_in;
         gain_ff <= gain_in;
         running_ff <= running_in;
         indicator_ff <= indicator_in;
         tick_ff <= tick_in;
         dose_ff <= dose_in;
         batch_ff <= batch_in;
         pending_ff <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
      mode_ff <= mode_in;
      stop_ff <= stop_in;
      product_ff <= product_in;
      next_ff <= next_in;
      tick_active_ff <= tick_active_in;
      end_ff <= end_in;
      report_batch_ff <= report_batch_in;
   end

`ifndef NO_ASSERTIONS
   a_done_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.run_done == (rsp_ff.end_status != diec_pkg::END_NONE)))
      else $error("run_done disagrees with end_status");

   a_ended_run_is_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.run_done) |-> (!rsp_ff.coil_on && !rsp_ff.active_led))
      else $error("ending result shows lamp or indicator on");
`endif

endmodule
